// File: sv/ssdp_pkg.sv
`default_nettype none
// ============================================================================
// ssdp_pkg
// Shared widths, register indexes and defaults for the stencil dot product.
// ============================================================================
package ssdp_pkg;

    localparam int MAX_TAPS_DEF = 5;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int FRAC_W   = 12;
    localparam int OUT_W    = 24;
    localparam int TAPS_W   = 3;
    localparam int ROWS_W   = 16;
    localparam int SEEN_W   = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF0 = 3'd2;

    localparam logic [TAPS_W-1:0] TAPS_RST = 3'd5;
    localparam logic [ROWS_W-1:0] ROWS_RST = 16'd16;
    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

endpackage
`default_nettype wire

// File: sv/ssdp_tap_cell.sv
`default_nettype none
// ============================================================================
// ssdp_tap_cell
// One tap: holds one window sample, passes it on, registers coef x sample.
// ============================================================================
module ssdp_tap_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic signed [ssdp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [ssdp_pkg::COEF_W-1:0]   i_coef,
    output logic signed      [ssdp_pkg::SAMPLE_W-1:0] o_sample,
    output logic signed      [ssdp_pkg::PROD_W-1:0]   o_prod
);

    logic signed [ssdp_pkg::SAMPLE_W-1:0] r_hold;
    logic signed [ssdp_pkg::PROD_W-1:0]   r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_prod <= '0;
        end else if (i_accept) begin
            r_hold <= i_sample;
            r_prod <= i_coef * i_sample;
        end
    end

    assign o_sample = r_hold;
    assign o_prod   = r_prod;

endmodule
`default_nettype wire

// File: sv/sliding_stencil_dot_product.sv
`default_nettype none
// ============================================================================
// sliding_stencil_dot_product
// Sliding-window stencil correlation over a row of tap cells.
// ============================================================================
// Pipeline: a request accepted at a rising edge is held in the product
//   register, then in the sum register, which drives the output.
// Throughput: one sample per cycle unless o_stall is high; each tap cell
//   has its own multiplier; the products are summed in the stage after them.
// Reset (synchronous, active low): config returns to taps 5, rows 16, coefs 0;
//   the sample count, window samples and pipeline valids clear.
// ============================================================================
module sliding_stencil_dot_product #(
    parameter int MAX_TAPS = ssdp_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration writes
    input  wire logic                                   i_cfg_we,
    input  wire logic [ssdp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [ssdp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // sample requests
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [ssdp_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic                                   i_first,
    // result requests
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed      [ssdp_pkg::OUT_W-1:0]      o_filtered,
    output logic                                        o_last_row
);

    localparam int SAMPLE_W = ssdp_pkg::SAMPLE_W;
    localparam int COEF_W   = ssdp_pkg::COEF_W;
    localparam int PROD_W   = ssdp_pkg::PROD_W;
    localparam int ACC_W    = ssdp_pkg::ACC_W;
    localparam int TAPS_W   = ssdp_pkg::TAPS_W;
    localparam int ROWS_W   = ssdp_pkg::ROWS_W;
    localparam int SEEN_W   = ssdp_pkg::SEEN_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [TAPS_W-1:0] r_taps;
    logic        [ROWS_W-1:0] r_rows;
    logic signed [COEF_W-1:0] r_coef [MAX_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= ssdp_pkg::TAPS_RST;
            r_rows <= ssdp_pkg::ROWS_RST;
            for (int j = 0; j < MAX_TAPS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ssdp_pkg::CFG_TAPS) begin
                r_taps <= i_cfg_data[TAPS_W-1:0];
            end
            if (i_cfg_idx == ssdp_pkg::CFG_ROWS) begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (int'(i_cfg_idx) == int'(ssdp_pkg::CFG_COEF0) + j) begin
                    r_coef[j] <= i_cfg_data[COEF_W-1:0];
                end
            end
        end
    end

    // effective tap count: zero acts as one, overflow clamps to MAX_TAPS
    logic [TAPS_W-1:0] w_taps;
    always_comb begin
        if (r_taps == '0) begin
            w_taps = TAPS_W'(1);
        end else if (int'(r_taps) > MAX_TAPS) begin
            w_taps = TAPS_W'(MAX_TAPS);
        end else begin
            w_taps = r_taps;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: two stage pipeline, bubbles collapse
    // ------------------------------------------------------------------
    logic r_v1, r_last1;
    logic r_v2, r_last2;
    logic w_en2, w_en1, w_accept;

    assign w_en2    = !r_v2 || !i_stall;
    assign w_en1    = !r_v1 || w_en2;
    assign o_stall  = !w_en1;
    assign w_accept = i_valid && w_en1;

    // ------------------------------------------------------------------
    // Row tracking: count samples of the vector, decide result and last
    // ------------------------------------------------------------------
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [SEEN_W-1:0] w_row_idx;
    logic              w_produce, w_last;

    always_comb begin
        if (i_first) begin
            n_seen = SEEN_W'(1);
        end else if (r_seen != ssdp_pkg::SEEN_MAX) begin
            n_seen = r_seen + SEEN_W'(1);
        end else begin
            n_seen = r_seen;
        end
        w_row_idx = n_seen - SEEN_W'(w_taps);
        w_produce = (n_seen >= SEEN_W'(w_taps)) && (w_row_idx < SEEN_W'(r_rows));
        w_last    = (w_row_idx == SEEN_W'(r_rows) - SEEN_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_accept) begin
            r_seen <= n_seen;
        end
    end

    // ------------------------------------------------------------------
    // Tap chain. Cell a sees the sample of age a (cell 0 the new one) and
    // weights it by coef[taps-1-a]; cells past the tap count get zero.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] w_chain [MAX_TAPS+1];
    logic signed [COEF_W-1:0]   w_coef_sel [MAX_TAPS];
    logic signed [PROD_W-1:0]   w_prod [MAX_TAPS];

    assign w_chain[0] = i_sample;

    always_comb begin
        for (int a = 0; a < MAX_TAPS; a++) begin
            w_coef_sel[a] = '0;
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (a < int'(w_taps) && j == int'(w_taps) - 1 - a) begin
                    w_coef_sel[a] = r_coef[j];
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_tap
        ssdp_tap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_sample (w_chain[g]),
            .i_coef   (w_coef_sel[g]),
            .o_sample (w_chain[g+1]),
            .o_prod   (w_prod[g])
        );
    end

    // sum of the registered products
    logic signed [ACC_W-1:0] w_sum;
    always_comb begin
        w_sum = '0;
        for (int a = 0; a < MAX_TAPS; a++) begin
            w_sum = w_sum + ACC_W'(w_prod[a]);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control and output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept && w_produce;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last1 <= w_last;
        end
        if (w_en2 && r_v1) begin
            r_sum   <= w_sum;
            r_last2 <= r_last1;
        end
    end

    // floor shift by the fraction bits, keep the result width
    assign o_valid    = r_v2;
    assign o_filtered = r_sum[ssdp_pkg::FRAC_W+ssdp_pkg::OUT_W-1:ssdp_pkg::FRAC_W];
    assign o_last_row = r_last2;

endmodule
`default_nettype wire
